// ===== design/wpm_pkg.sv =====
// Package for the wildcard pattern matcher: sizes, codes, request and
// result types, and the records passed along the row of match cells.
// No dependencies.
package wpm_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int DRAIN_W = $clog2(MAX_PATTERN + 2);

  localparam logic [7:0] STAR_CODE  = 8'd42;
  localparam logic [7:0] QMARK_CODE = 8'd63;

  typedef enum logic [1:0] {
    KIND_PATTERN = 2'd0,
    KIND_TEXT    = 2'd1,
    KIND_FINISH  = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_ORDER    = 2'd2
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_code;
  } in_t;

  typedef struct packed {
    logic    matched;
    status_t status;
  } out_t;

  // One text character on its way down the row, with the neighbor's
  // match bit before and after this character.
  typedef struct packed {
    logic       valid;
    logic [7:0] char_code;
    logic       old_bit;
    logic       upd_bit;
  } wave_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic             restart;
    logic             clear;
    logic             append;
    logic [7:0]       pat_char;
    logic [LEN_W-1:0] length;
  } cell_ctl_t;

endpackage

// ===== design/wpm_cell.sv =====
// One pattern position of the matcher: its pattern byte, initial-row bit
// and current match bit. Uses wpm_pkg.
module wpm_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [wpm_pkg::IDX_W-1:0] idx,
  input  wpm_pkg::cell_ctl_t       ctl,
  input  wpm_pkg::wave_t           wave_in,
  input  logic                     init_in,
  output wpm_pkg::wave_t           wave_out,
  output logic                     init_out,
  output logic                     tap
);

  logic [7:0] pat;
  logic       init_bit;
  logic       match_bit;
  logic       wave_valid;
  logic [7:0] wave_char;
  logic       wave_old;
  logic       wave_upd;
  logic       active;
  logic       is_last;
  logic       load;
  logic       load_init;
  logic       upd;

  assign active  = wpm_pkg::LEN_W'(idx) < ctl.length;
  assign is_last = ctl.length == (wpm_pkg::LEN_W'(idx) + wpm_pkg::LEN_W'(1));
  assign load    = ctl.append && (ctl.length == wpm_pkg::LEN_W'(idx));
  assign load_init = (ctl.pat_char == wpm_pkg::STAR_CODE) ? init_in : 1'b0;

  // Exact (tried first, even for '*' on a text '*') or '?' takes the left
  // neighbor's old bit; '*' extends either from above (own old bit) or from the left neighbor's new bit.
  always_comb begin
    upd = 1'b0;
    if (active) begin
      if (pat == wave_in.char_code || pat == wpm_pkg::QMARK_CODE) begin
        upd = wave_in.old_bit;
      end else if (pat == wpm_pkg::STAR_CODE) begin
        upd = match_bit | wave_in.upd_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      init_bit   <= 1'b0;
      match_bit  <= 1'b0;
      wave_valid <= 1'b0;
    end else begin
      wave_valid <= wave_in.valid;
      if (load) begin
        init_bit <= load_init;
      end
      if (ctl.restart) begin
        match_bit <= load ? load_init : init_bit;
      end else if (wave_in.valid) begin
        match_bit <= upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pat <= ctl.pat_char;
    end
    wave_char <= wave_in.char_code;
    wave_old  <= active ? match_bit : 1'b0;
    wave_upd  <= upd;
  end

  assign wave_out = '{valid: wave_valid, char_code: wave_char,
                      old_bit: wave_old, upd_bit: wave_upd};
  assign init_out = init_bit;
  assign tap      = match_bit & is_last;

endmodule

// ===== design/wildcard_pattern_matcher_unit.sv =====
// Top level of the wildcard pattern matcher: request decode, head of the
// match row, the row of wpm_cell instances and the result register.
// Uses wpm_pkg and wpm_cell.
//
// Usage:
//   Requests enter on in_valid/in_ready/in_data, each one of: append a
//   pattern byte, a text byte, finish the text, or clear the pattern.
//   Only a finish makes a result, sent on out_valid/out_ready/out_data
//   with the match flag and the sticky status (overflow or pattern after
//   text); any nonzero status forces matched low.
//   Text bytes travel down the row of MAX_PATTERN cells one cell per
//   cycle, so a new text byte is taken every cycle. Append, finish and
//   clear wait until the last text byte has left the whole row; the
//   drain counter, reloaded by each text byte taken, holds them off
//   until then. Once the row has drained they are taken back to back.
//   A finish shows its result the cycle after it is taken.
//   A finish is held off while the result register is full and the
//   receiver stalls; text bytes keep flowing regardless.
//   Reset empties the pattern, clears the status and the match row; the
//   pattern bytes themselves are not cleared.
module wildcard_pattern_matcher_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  wpm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output wpm_pkg::out_t out_data
);

  logic [wpm_pkg::LEN_W-1:0]   length;
  logic                        text_started;
  wpm_pkg::status_t            err;
  wpm_pkg::status_t            err_next;
  logic                        row0;
  logic [wpm_pkg::DRAIN_W-1:0] drain;

  logic head_valid;
  logic [7:0] head_char;
  logic head_old;

  logic acc;
  logic idle;
  logic do_pat;
  logic do_text;
  logic do_finish;
  logic do_clear;
  logic pat_ok;
  logic full;
  logic hit;

  wpm_pkg::cell_ctl_t                ctl;
  wpm_pkg::wave_t                    wave [0:wpm_pkg::MAX_PATTERN];
  logic [wpm_pkg::MAX_PATTERN:0]     init_row;
  logic [wpm_pkg::MAX_PATTERN-1:0]   taps;

  assign idle = drain == '0;
  assign full = length == wpm_pkg::LEN_W'(wpm_pkg::MAX_PATTERN);

  // Text streams freely; everything else waits for the row to drain, a finish also for room in the result register.
  always_comb begin
    unique case (in_data.kind) inside
      wpm_pkg::KIND_TEXT:   in_ready = 1'b1;
      wpm_pkg::KIND_FINISH: in_ready = idle && (!out_valid || out_ready);
      wpm_pkg::KIND_PATTERN, wpm_pkg::KIND_CLEAR: in_ready = idle;
      default:              in_ready = 1'b0;
    endcase
  end

  assign acc       = in_valid && in_ready;
  assign do_pat    = acc && (in_data.kind == wpm_pkg::KIND_PATTERN);
  assign do_text   = acc && (in_data.kind == wpm_pkg::KIND_TEXT);
  assign do_finish = acc && (in_data.kind == wpm_pkg::KIND_FINISH);
  assign do_clear  = acc && (in_data.kind == wpm_pkg::KIND_CLEAR);
  assign pat_ok    = do_pat && !text_started && !full;

  // Keep the first error until a clear.
  always_comb begin
    err_next = err;
    if (do_pat && err == wpm_pkg::STATUS_OK) begin
      if (text_started) begin
        err_next = wpm_pkg::STATUS_ORDER;
      end else if (full) begin
        err_next = wpm_pkg::STATUS_OVERFLOW;
      end
    end
  end

  assign ctl = '{restart: do_finish || pat_ok, clear: do_clear, append: pat_ok,
                 pat_char: in_data.char_code, length: length};

  // Row head: bit zero of the match row and the entry of each text wave.
  assign wave[0]     = '{valid: head_valid, char_code: head_char,
                         old_bit: head_old, upd_bit: 1'b0};
  assign init_row[0] = 1'b1;

  for (genvar k = 0; k < wpm_pkg::MAX_PATTERN; k++) begin : g_cell
    wpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (wpm_pkg::IDX_W'(k)),
      .ctl      (ctl),
      .wave_in  (wave[k]),
      .init_in  (init_row[k]),
      .wave_out (wave[k+1]),
      .init_out (init_row[k+1]),
      .tap      (taps[k])
    );
  end

  assign hit = (length == '0) ? row0 : |taps;

  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      length       <= '0;
      text_started <= 1'b0;
      err          <= wpm_pkg::STATUS_OK;
      row0         <= 1'b1;
      head_valid   <= 1'b0;
    end else begin
      err        <= err_next;
      head_valid <= do_text;
      if (pat_ok) begin
        length <= length + wpm_pkg::LEN_W'(1);
      end
      if (do_text) begin
        text_started <= 1'b1;
        row0         <= 1'b0;
      end else if (do_finish || pat_ok) begin
        text_started <= 1'b0;
        row0         <= 1'b1;
      end
    end
  end

  // Head payload: advance the character and the old bit zero.
  always_ff @(posedge clk) begin
    head_char <= in_data.char_code;
    head_old  <= row0;
  end

  // Hold off control requests until the last wave clears the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      drain <= '0;
    end else if (do_text) begin
      drain <= wpm_pkg::DRAIN_W'(wpm_pkg::MAX_PATTERN + 1);
    end else if (!idle) begin
      drain <= drain - wpm_pkg::DRAIN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_finish) begin
      out_data <= '{matched: hit && (err == wpm_pkg::STATUS_OK), status: err};
    end
  end

  a_ctl_after_drain: assert property (@(posedge clk) disable iff (rst)
    (acc && !do_text) |-> idle)
    else $error("control request taken while a text wave is in flight");

  a_tail_drained: assert property (@(posedge clk) disable iff (rst)
    wave[wpm_pkg::MAX_PATTERN].valid |-> !idle)
    else $error("wave left the row after the drain counter expired");

  a_last_init: assert property (@(posedge clk) disable iff (rst)
    init_row[wpm_pkg::MAX_PATTERN] |-> full)
    else $error("last cell initial bit set without a full pattern");

  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.matched) |-> (out_data.status == wpm_pkg::STATUS_OK))
    else $error("match reported with an error status");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    do_clear |=> (length == '0) && (err == wpm_pkg::STATUS_OK) && row0)
    else $error("clear did not empty the pattern");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for wildcard_pattern_matcher_unit: queued requests, a
// clocked driver and monitor, and a bit-level row predictor of the match.
// Depends on wpm_pkg and the design files.
module tb_top;
  import wpm_pkg::*;

  localparam int PHASE_LEN    = 45;   // requests per idling phase
  localparam int TARGET_REQS  = 750;
  localparam int LONG_HOLD    = 300;  // receiver hold-off, in cycles
  localparam int SETTLE       = MAX_PATTERN + 8;

  typedef struct {
    in_t req;
    int  idle_pct;
    int  stall_pct;
    bit  long_hold;
    bit  drain_first;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  wildcard_pattern_matcher_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Requests waiting to go out, and the verdicts owed by the block.
  stim_t pending_reqs[$];
  out_t  expected_verdicts[$];

  // Shadow of the block: stored pattern, live match row and the row that
  // stands for the empty text.
  logic [7:0]           pat_store [MAX_PATTERN];
  int unsigned          pat_len = 0;
  logic [MAX_PATTERN:0] live_row = 1;
  logic [MAX_PATTERN:0] empty_row = 1;
  bit                   text_seen = 1'b0;
  status_t              err_code = STATUS_OK;

  int n_queued = 0;
  int n_requests = 0;
  int n_finishes = 0;
  int n_hits = 0;
  int n_flagged = 0;
  int n_failures = 0;

  // Stimulus shaping flags used while the queue is filled.
  bit burst_mode = 1'b0;
  bit mark_hold = 1'b0;
  bit mark_drain = 1'b0;

  // Handshake between driver and receiver process.
  int    stall_pct = 0;
  int    hold_requests = 0;
  int    hold_seen = 0;
  int    hold_left = 0;
  stim_t next_stim;

  // Advance the shadow by one accepted request; queue a verdict on finish.
  function automatic void apply_request(in_t req);
    logic [MAX_PATTERN:0] next_row;
    logic [7:0]           p;
    out_t                 verdict;
    case (req.kind)
      KIND_PATTERN: begin
        if (text_seen) begin
          if (err_code == STATUS_OK) err_code = STATUS_ORDER;
        end else if (pat_len >= MAX_PATTERN) begin
          if (err_code == STATUS_OK) err_code = STATUS_OVERFLOW;
        end else begin
          pat_store[pat_len] = req.char_code;
          pat_len++;
          // Empty text still matches while the pattern is all stars.
          empty_row[pat_len] = (req.char_code == STAR_CODE) && empty_row[pat_len-1];
          live_row = empty_row;
        end
      end
      KIND_TEXT: begin
        next_row = '0;
        for (int j = 1; j <= MAX_PATTERN; j++) begin
          if (j <= pat_len) begin
            p = pat_store[j-1];
            if (p == req.char_code || p == QMARK_CODE) begin
              next_row[j] = live_row[j-1];
            end else if (p == STAR_CODE) begin
              // Star either eats this byte or matches empty after j-1.
              next_row[j] = live_row[j] | next_row[j-1];
            end
          end
        end
        live_row = next_row;
        text_seen = 1'b1;
      end
      KIND_FINISH: begin
        verdict.matched = (err_code == STATUS_OK) ? live_row[pat_len] : 1'b0;
        verdict.status  = err_code;
        expected_verdicts.push_back(verdict);
        live_row = empty_row;
        text_seen = 1'b0;
        n_finishes++;
        if (verdict.matched) n_hits++;
        if (verdict.status != STATUS_OK) n_flagged++;
      end
      default: begin
        pat_len = 0;
        live_row = 1;
        empty_row = 1;
        text_seen = 1'b0;
        err_code = STATUS_OK;
      end
    endcase
  endfunction

  // Queue one request, tagged with the idling of the current phase.
  task automatic push_req(kind_t kind, logic [7:0] code);
    stim_t s;
    int    ph;
    ph = (n_queued / PHASE_LEN) % 4;
    s.req.kind = kind;
    s.req.char_code = code;
    s.idle_pct  = 0;
    s.stall_pct = 0;
    if (!burst_mode) begin
      case (ph)
        1: s.idle_pct = 87;
        2: s.stall_pct = 87;
        3: begin
          s.idle_pct = 6;
          s.stall_pct = 6;
        end
        default: ;
      endcase
    end
    s.long_hold = mark_hold;
    s.drain_first = mark_drain;
    mark_hold = 1'b0;
    mark_drain = 1'b0;
    pending_reqs.push_back(s);
    n_queued++;
  endtask

  // Pattern bytes lean on stars, question marks and a tiny alphabet so that
  // matches actually happen; now and then any byte at all.
  function automatic logic [7:0] pattern_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return STAR_CODE;
    if (r == 2) return QMARK_CODE;
    if (r == 9) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(97, 99));
  endfunction

  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(97, 99));
  endfunction

  task automatic push_pattern(int n);
    repeat (n) push_req(KIND_PATTERN, pattern_byte());
  endtask

  task automatic push_text(int n);
    repeat (n) push_req(KIND_TEXT, text_byte());
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Fill the queue: directed cases first, then random sequences.
  initial begin : fill_requests
    int  sel;
    bit  burst_done;
    burst_done = 1'b0;

    // Empty pattern against empty and nonempty text.
    push_req(KIND_FINISH, any_byte());
    push_req(KIND_TEXT, "a");
    push_req(KIND_FINISH, any_byte());
    // Lone star: empty text and extreme bytes both match.
    push_req(KIND_PATTERN, STAR_CODE);
    push_req(KIND_FINISH, any_byte());
    push_req(KIND_TEXT, 8'h00);
    push_req(KIND_TEXT, 8'hFF);
    push_req(KIND_FINISH, any_byte());
    // Extend the pattern after a finish: no error.
    push_req(KIND_PATTERN, QMARK_CODE);
    push_req(KIND_TEXT, "x");
    push_req(KIND_FINISH, any_byte());
    push_req(KIND_FINISH, any_byte());
    // Pattern byte after text, then the error stays sticky.
    push_req(KIND_TEXT, "q");
    push_req(KIND_PATTERN, "a");
    push_req(KIND_FINISH, any_byte());
    push_req(KIND_PATTERN, "b");
    push_req(KIND_FINISH, any_byte());
    // Clear drops the error; literal extreme bytes.
    push_req(KIND_CLEAR, 8'hFF);
    push_req(KIND_PATTERN, 8'hFF);
    push_req(KIND_PATTERN, 8'h00);
    push_req(KIND_TEXT, 8'hFF);
    push_req(KIND_TEXT, 8'h00);
    push_req(KIND_FINISH, any_byte());
    push_req(KIND_CLEAR, 8'h00);

    // Full store, then one byte too many.
    push_pattern(MAX_PATTERN);
    push_text($urandom_range(0, 40));
    push_req(KIND_FINISH, any_byte());
    push_req(KIND_PATTERN, pattern_byte());
    push_req(KIND_FINISH, any_byte());
    push_req(KIND_CLEAR, any_byte());

    while (n_queued < TARGET_REQS) begin
      if (!burst_done && n_queued >= 350) begin
        // Hold the receiver off while finishes keep coming, so the result
        // register fills and the input stalls; then drain fully.
        burst_done = 1'b1;
        burst_mode = 1'b1;
        mark_hold = 1'b1;
        push_req(KIND_CLEAR, any_byte());
        push_req(KIND_PATTERN, "a");
        push_req(KIND_PATTERN, STAR_CODE);
        repeat (3) push_req(KIND_FINISH, any_byte());
        repeat (3) begin
          push_req(KIND_TEXT, "a");
          push_req(KIND_FINISH, any_byte());
        end
        burst_mode = 1'b0;
        mark_drain = 1'b1;
        push_req(KIND_CLEAR, any_byte());
      end
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        // Well-formed: optional clear, a few pattern bytes, several texts.
        if ($urandom_range(0, 3) == 0) push_req(KIND_CLEAR, any_byte());
        push_pattern($urandom_range(0, 6));
        repeat ($urandom_range(1, 3)) begin
          push_text($urandom_range(0, 8));
          push_req(KIND_FINISH, any_byte());
        end
      end else if (sel < 76) begin
        // Long pattern around the store size.
        push_req(KIND_CLEAR, any_byte());
        push_pattern($urandom_range(MAX_PATTERN - 4, MAX_PATTERN + 3));
        repeat ($urandom_range(1, 2)) begin
          push_text($urandom_range(0, 20));
          push_req(KIND_FINISH, any_byte());
        end
      end else if (sel < 88) begin
        // Broken: pattern bytes slipped in among text.
        push_text($urandom_range(1, 3));
        push_pattern($urandom_range(1, 2));
        push_text($urandom_range(0, 2));
        push_req(KIND_FINISH, any_byte());
      end else begin
        // Noise: any kind, any byte.
        repeat ($urandom_range(1, 4))
          push_req(kind_t'($urandom_range(0, 3)), any_byte());
      end
    end
  end

  // Reset once, then wait for the queue and the verdicts to run dry.
  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    // Let any stray result show up before judging.
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d requests and %0d finishes: %0d matches, %0d with error status.",
             n_requests, n_finishes, n_hits, n_flagged);
    $display("Idling phases: none, sender, receiver, both; one long receiver hold-off.");
    if (n_failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Driver: predict on acceptance, then present the next request or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(in_data);
        n_requests++;
      end
      if (!in_valid || in_ready) begin
        // Hold off when the queue is empty, when the next request wants
        // every verdict back first, or on a random idle cycle.
        if (pending_reqs.size() == 0 ||
            (pending_reqs[0].drain_first && expected_verdicts.size() != 0) ||
            $urandom_range(0, 99) < pending_reqs[0].idle_pct) begin
          in_valid <= 1'b0;
        end else begin
          next_stim = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_data <= next_stim.req;
          stall_pct <= next_stim.stall_pct;
          if (next_stim.long_hold) hold_requests <= hold_requests + 1;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest verdict owed.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        if (n_failures < 10)
          $display("ERROR: result with none owed: matched=%0b status=%0d",
                   out_data.matched, out_data.status);
        n_failures++;
      end else begin
        if (out_data.matched !== expected_verdicts[0].matched ||
            out_data.status !== expected_verdicts[0].status) begin
          if (n_failures < 10)
            $display("ERROR: matched exp %0b got %0b, status exp %0d got %0d",
                     expected_verdicts[0].matched, out_data.matched,
                     expected_verdicts[0].status, out_data.status);
          n_failures++;
        end
        void'(expected_verdicts.pop_front());
      end
    end
  end

  // Drop the run if it hangs.
  initial begin
    #(8 * 600_000);
    $display("Timeout: %0d verdicts still owed", expected_verdicts.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
